[design/dct_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dct_pkg
// Shared types, constants and calendar tables of the calendar tick block.
// ----------------------------------------------------------------------------
package dct_pkg;

    localparam int BASE_YEAR = 2000;
    localparam int YEAR_SPAN = 135;

    localparam logic [11:0] YEAR_MIN = 12'(BASE_YEAR);
    localparam logic [11:0] YEAR_MAX = 12'(BASE_YEAR + YEAR_SPAN);

    localparam int BASE_CY = BASE_YEAR - 1;
    localparam int BASE_WD_I = (BASE_CY + BASE_CY / 4 - BASE_CY / 100 + BASE_CY / 400 + 36) % 7;
    localparam logic [2:0] BASE_WD = 3'(BASE_WD_I);

    localparam logic [1:0] BASE_MOD4   = 2'(BASE_YEAR % 4);
    localparam logic [6:0] BASE_MOD100 = 7'(BASE_YEAR % 100);
    localparam logic [8:0] BASE_MOD400 = 9'(BASE_YEAR % 400);

    localparam logic [24:0] DIV100_MUL = 25'd5243;
    localparam logic [26:0] DIV7_MUL   = 27'd9363;

    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_TICK   = 4'd2;
    localparam logic [3:0] OP_DIV    = 4'd3;
    localparam logic [3:0] OP_SUM    = 4'd4;
    localparam logic [3:0] OP_MOD    = 4'd5;
    localparam logic [3:0] OP_REM    = 4'd6;
    localparam logic [3:0] OP_FAIL   = 4'd7;
    localparam logic [3:0] OP_SWINIT = 4'd8;
    localparam logic [3:0] OP_SWEEP  = 4'd9;
    localparam logic [3:0] OP_DAYS   = 4'd10;
    localparam logic [3:0] OP_MUL    = 4'd11;
    localparam logic [3:0] OP_COMMIT = 4'd12;
    localparam logic [3:0] OP_OUT    = 4'd13;

    localparam logic [1:0] SEL_MAR  = 2'd0;
    localparam logic [1:0] SEL_OCT  = 2'd1;
    localparam logic [1:0] SEL_DATE = 2'd2;

    typedef struct packed {
        logic        req_type;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } dct_req_t;

    typedef struct packed {
        logic        status;
        logic [11:0] now_year;
        logic [3:0]  now_month;
        logic [4:0]  now_day;
        logic [4:0]  now_hour;
        logic [5:0]  now_minute;
        logic [5:0]  now_second;
        logic [2:0]  weekday;
        logic        summer_time;
        logic [31:0] utc_seconds;
    } dct_res_t;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] sel;
    } dct_cmd_t;

    typedef struct packed {
        logic is_set;
        logic roll;
        logic date_ok;
        logic sweep_done;
        logic out_free;
    } dct_sts_t;

    function automatic logic [3:0] cm_term(input logic [4:0] cm);
        logic [3:0] r;
        case (cm)
            5'd3:    r = 4'd2;
            5'd4:    r = 4'd3;
            5'd5:    r = 4'd3;
            5'd6:    r = 4'd4;
            5'd7:    r = 4'd4;
            5'd8:    r = 4'd5;
            5'd9:    r = 4'd6;
            5'd10:   r = 4'd6;
            5'd11:   r = 4'd7;
            5'd12:   r = 4'd7;
            5'd13:   r = 4'd8;
            5'd14:   r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        case (m)
            4'd2:                      r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:        r = 5'd31;
            default:                   r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
        logic [8:0] b;
        case (m)
            4'd2:    b = 9'd31;
            4'd3:    b = 9'd59;
            4'd4:    b = 9'd90;
            4'd5:    b = 9'd120;
            4'd6:    b = 9'd151;
            4'd7:    b = 9'd181;
            4'd8:    b = 9'd212;
            4'd9:    b = 9'd243;
            4'd10:   b = 9'd273;
            4'd11:   b = 9'd304;
            4'd12:   b = 9'd334;
            default: b = 9'd0;
        endcase
        return b + 9'(leap && (m > 4'd2));
    endfunction

endpackage
`default_nettype wire

[design/dst_calendar_tick.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dst_calendar_tick
// Calendar with a UTC seconds count and daylight-saving switch points.
// ----------------------------------------------------------------------------
// A tick word passes through the load, tick and roll-check states and then registers
// its result word; a new word is taken only once that result word is registered.
// A set word first checks its date: an illegal one returns a failed status, a legal
// one also sweeps the years from the base year. A tick that rolls the year sweeps too.
// One word is in flight at a time; a stalled result holds it.
// Reset is synchronous and active low and loads 1 January of the base year.
module dst_calendar_tick import dct_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire dct_req_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output dct_res_t      m_data
);

    dct_cmd_t cmd;
    dct_sts_t sts;

    dct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .req_type (s_data.req_type),
        .s_ready  (s_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dct_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

[design/dct_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dct_datapath
// Calendar state, weekday unit, year sweep, count multiplier and result word.
// ----------------------------------------------------------------------------
module dct_datapath import dct_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire dct_cmd_t cmd,
    output dct_sts_t      sts,
    input  wire dct_req_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output dct_res_t      m_data
);

    logic [31:0] utc_reg, start_reg, end_reg, loc_reg;
    logic [11:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg, hour_reg;
    logic [5:0]  min_reg, sec_reg;
    logic [2:0]  wd_reg, wd_mar_reg, wd_oct_reg, wd_set_reg;
    logic        leap_reg, aleap_reg, status_reg, roll_reg, m_valid_reg;
    dct_req_t    req_reg;
    dct_res_t    m_data_reg;
    logic [11:0] ay_reg, sweep_y_reg;
    logic [5:0]  q100_reg;
    logic [12:0] wsum_reg;
    logic [9:0]  q7_reg;
    logic [1:0]  m4_reg;
    logic [6:0]  m100_reg;
    logic [8:0]  m400_reg;
    logic [19:0] dby_reg, days_reg;

    logic [11:0] cy;
    logic [4:0]  cm, wdd;
    logic [24:0] prod100;
    logic [12:0] wsum_next, rem_val;
    logic [26:0] prod7;
    logic [11:0] hund;
    logic        aleap_next, sweep_leap, date_ok;
    logic [19:0] days_next;
    logic [36:0] pfull;
    logic [31:0] offs, cnt_next, utc1, utc_set_next;

    logic [31:0] t_utc_next;
    logic [5:0]  t_sec_next, t_min_next;
    logic [4:0]  t_hour_next, t_day_next;
    logic [3:0]  t_month_next;
    logic [11:0] t_year_next;
    logic [2:0]  t_wd_next;
    logic        t_roll_next;

    always_comb begin
        cy  = ay_reg;
        cm  = 5'd3;
        wdd = 5'd31;
        case (cmd.sel)
            SEL_OCT: begin
                cm = 5'd10;
            end
            SEL_DATE: begin
                wdd = req_reg.day;
                if (req_reg.month < 4'd3) begin
                    cy = ay_reg - 12'd1;
                    cm = {1'b0, req_reg.month} + 5'd12;
                end else begin
                    cm = {1'b0, req_reg.month};
                end
            end
            default: begin
                cm = 5'd3;
            end
        endcase
    end

    assign prod100   = {13'b0, cy} * DIV100_MUL;
    assign wsum_next = 13'(wdd) + 13'({cm, 1'b0}) + 13'(cm_term(cm)) + 13'(cy)
                     + 13'(cy[11:2]) - 13'(q100_reg) + 13'(q100_reg[5:2]) + 13'd1;
    assign prod7     = {14'b0, wsum_reg} * DIV7_MUL;
    assign rem_val   = wsum_reg - 13'({3'b0, q7_reg} * 13'd7);
    assign hund      = {6'b0, q100_reg} * 12'd100;
    assign aleap_next = (cy[1:0] == 2'd0) && ((cy != hund) || (q100_reg[1:0] == 2'd0));

    assign date_ok = (req_reg.year >= YEAR_MIN) && (req_reg.year <= YEAR_MAX)
                   && (req_reg.month >= 4'd1) && (req_reg.month <= 4'd12)
                   && (req_reg.day >= 5'd1)
                   && (req_reg.day <= month_days(req_reg.month, aleap_reg))
                   && (req_reg.hour <= 5'd23) && (req_reg.minute <= 6'd59)
                   && (req_reg.second <= 6'd59);

    assign sweep_leap = (m400_reg == 9'd0) || ((m100_reg != 7'd0) && (m4_reg == 2'd0));

    always_comb begin
        case (cmd.sel)
            SEL_OCT: begin
                days_next = dby_reg + 20'(days_before(4'd10, aleap_reg)) + 20'd30
                          - 20'(wd_oct_reg);
                offs = 32'd3600;
            end
            SEL_DATE: begin
                days_next = dby_reg + 20'(days_before(req_reg.month, aleap_reg))
                          + 20'(req_reg.day) - 20'd1;
                offs = 32'(req_reg.hour) * 32'd3600 + 32'(req_reg.minute) * 32'd60
                     + 32'(req_reg.second);
            end
            default: begin
                days_next = dby_reg + 20'(days_before(4'd3, aleap_reg)) + 20'd30
                          - 20'(wd_mar_reg);
                offs = 32'd3600;
            end
        endcase
    end

    assign pfull    = {17'b0, days_reg} * 37'd86400;
    assign cnt_next = pfull[31:0] + offs;
    assign utc1     = loc_reg - 32'd3600;
    assign utc_set_next = ((utc1 > start_reg) && (utc1 < end_reg)) ?
                          (loc_reg - 32'd7200) : utc1;

    always_comb begin
        t_utc_next   = utc_reg + 32'd1;
        t_hour_next  = hour_reg;
        t_sec_next   = sec_reg + 6'd1;
        t_min_next   = min_reg;
        t_day_next   = day_reg;
        t_month_next = month_reg;
        t_year_next  = year_reg;
        t_wd_next    = wd_reg;
        t_roll_next  = 1'b0;
        if (t_utc_next == start_reg) begin
            t_hour_next = t_hour_next + 5'd1;
        end
        if (t_utc_next == end_reg) begin
            t_hour_next = t_hour_next - 5'd1;
        end
        if (t_sec_next >= 6'd60) begin
            t_sec_next = 6'd0;
            t_min_next = min_reg + 6'd1;
            if (t_min_next >= 6'd60) begin
                t_min_next  = 6'd0;
                t_hour_next = t_hour_next + 5'd1;
                if (t_hour_next >= 5'd24) begin
                    t_hour_next = 5'd0;
                    t_wd_next   = (wd_reg >= 3'd6) ? 3'd0 : wd_reg + 3'd1;
                    t_day_next  = day_reg + 5'd1;
                    if (day_reg >= month_days(month_reg, leap_reg)) begin
                        t_day_next   = 5'd1;
                        t_month_next = month_reg + 4'd1;
                        if (t_month_next > 4'd12) begin
                            t_month_next = 4'd1;
                            t_year_next  = year_reg + 12'd1;
                            t_roll_next  = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            utc_reg     <= '0;
            start_reg   <= '0;
            end_reg     <= '0;
            year_reg    <= YEAR_MIN;
            month_reg   <= 4'd1;
            day_reg     <= 5'd1;
            hour_reg    <= '0;
            min_reg     <= '0;
            sec_reg     <= '0;
            wd_reg      <= BASE_WD;
            leap_reg    <= (BASE_YEAR % 400 == 0) || ((BASE_YEAR % 100 != 0) && (BASE_YEAR % 4 == 0));
            m_valid_reg <= 1'b0;
            status_reg  <= 1'b0;
            roll_reg    <= 1'b0;
        end else begin
            if (cmd.op == OP_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_LOAD: begin
                    status_reg <= 1'b0;
                    roll_reg   <= 1'b0;
                end
                OP_TICK: begin
                    utc_reg   <= t_utc_next;
                    hour_reg  <= t_hour_next;
                    sec_reg   <= t_sec_next;
                    min_reg   <= t_min_next;
                    day_reg   <= t_day_next;
                    month_reg <= t_month_next;
                    year_reg  <= t_year_next;
                    wd_reg    <= t_wd_next;
                    roll_reg  <= t_roll_next;
                end
                OP_FAIL: begin
                    status_reg <= 1'b1;
                end
                OP_MUL: begin
                    if (cmd.sel == SEL_MAR) begin
                        start_reg <= cnt_next;
                    end else if (cmd.sel == SEL_OCT) begin
                        end_reg <= cnt_next;
                    end
                end
                OP_COMMIT: begin
                    leap_reg <= aleap_reg;
                    if (req_reg.req_type) begin
                        utc_reg   <= utc_set_next;
                        year_reg  <= req_reg.year;
                        month_reg <= req_reg.month;
                        day_reg   <= req_reg.day;
                        hour_reg  <= req_reg.hour;
                        min_reg   <= req_reg.minute;
                        sec_reg   <= req_reg.second;
                        wd_reg    <= wd_set_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                req_reg <= s_data;
                ay_reg  <= s_data.year;
            end
            OP_TICK: begin
                ay_reg <= t_year_next;
            end
            OP_DIV: begin
                q100_reg <= prod100[24:19];
            end
            OP_SUM: begin
                wsum_reg <= wsum_next;
                if (cmd.sel == SEL_MAR) begin
                    aleap_reg <= aleap_next;
                end
            end
            OP_MOD: begin
                q7_reg <= prod7[25:16];
            end
            OP_REM: begin
                if (cmd.sel == SEL_MAR) begin
                    wd_mar_reg <= rem_val[2:0];
                end else if (cmd.sel == SEL_OCT) begin
                    wd_oct_reg <= rem_val[2:0];
                end else begin
                    wd_set_reg <= rem_val[2:0];
                end
            end
            OP_SWINIT: begin
                sweep_y_reg <= YEAR_MIN;
                m4_reg      <= BASE_MOD4;
                m100_reg    <= BASE_MOD100;
                m400_reg    <= BASE_MOD400;
                dby_reg     <= '0;
            end
            OP_SWEEP: begin
                sweep_y_reg <= sweep_y_reg + 12'd1;
                m4_reg      <= m4_reg + 2'd1;
                m100_reg    <= (m100_reg == 7'd99) ? 7'd0 : m100_reg + 7'd1;
                m400_reg    <= (m400_reg == 9'd399) ? 9'd0 : m400_reg + 9'd1;
                dby_reg     <= dby_reg + (sweep_leap ? 20'd366 : 20'd365);
            end
            OP_DAYS: begin
                days_reg <= days_next;
            end
            OP_MUL: begin
                if (cmd.sel == SEL_DATE) begin
                    loc_reg <= cnt_next;
                end
            end
            OP_OUT: begin
                m_data_reg.status      <= status_reg;
                m_data_reg.now_year    <= year_reg;
                m_data_reg.now_month   <= month_reg;
                m_data_reg.now_day     <= day_reg;
                m_data_reg.now_hour    <= hour_reg;
                m_data_reg.now_minute  <= min_reg;
                m_data_reg.now_second  <= sec_reg;
                m_data_reg.weekday     <= wd_reg;
                m_data_reg.summer_time <= (utc_reg >= start_reg) && (utc_reg < end_reg);
                m_data_reg.utc_seconds <= utc_reg;
            end
            default: begin
            end
        endcase
    end

    assign sts.is_set     = req_reg.req_type;
    assign sts.roll       = roll_reg;
    assign sts.date_ok    = date_ok;
    assign sts.sweep_done = !(sweep_y_reg < ay_reg);
    assign sts.out_free   = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

[design/dct_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dct_ctrl
// Sequencer that steps the datapath through tick, set and year analysis.
// ----------------------------------------------------------------------------
module dct_ctrl import dct_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    input  wire logic     req_type,
    output logic          s_ready,
    input  wire dct_sts_t sts,
    output dct_cmd_t      cmd
);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_TICK   = 5'd1;
    localparam logic [4:0] ST_ROLL   = 5'd2;
    localparam logic [4:0] ST_DIV_M  = 5'd3;
    localparam logic [4:0] ST_SUM_M  = 5'd4;
    localparam logic [4:0] ST_MOD_M  = 5'd5;
    localparam logic [4:0] ST_REM_M  = 5'd6;
    localparam logic [4:0] ST_FAIL   = 5'd7;
    localparam logic [4:0] ST_DIV_O  = 5'd8;
    localparam logic [4:0] ST_SUM_O  = 5'd9;
    localparam logic [4:0] ST_MOD_O  = 5'd10;
    localparam logic [4:0] ST_REM_O  = 5'd11;
    localparam logic [4:0] ST_SWINIT = 5'd12;
    localparam logic [4:0] ST_SWEEP  = 5'd13;
    localparam logic [4:0] ST_DAYS_M = 5'd14;
    localparam logic [4:0] ST_MUL_M  = 5'd15;
    localparam logic [4:0] ST_DAYS_O = 5'd16;
    localparam logic [4:0] ST_MUL_O  = 5'd17;
    localparam logic [4:0] ST_DIV_D  = 5'd18;
    localparam logic [4:0] ST_SUM_D  = 5'd19;
    localparam logic [4:0] ST_MOD_D  = 5'd20;
    localparam logic [4:0] ST_REM_D  = 5'd21;
    localparam logic [4:0] ST_DAYS_D = 5'd22;
    localparam logic [4:0] ST_MUL_D  = 5'd23;
    localparam logic [4:0] ST_COMMIT = 5'd24;
    localparam logic [4:0] ST_DONE   = 5'd25;

    logic [4:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.sel    = SEL_MAR;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = req_type ? ST_DIV_M : ST_TICK;
                end
            end
            ST_TICK: begin
                cmd.op     = OP_TICK;
                state_next = ST_ROLL;
            end
            ST_ROLL: begin
                state_next = sts.roll ? ST_DIV_M : ST_DONE;
            end
            ST_DIV_M: begin
                cmd.op     = OP_DIV;
                state_next = ST_SUM_M;
            end
            ST_SUM_M: begin
                cmd.op     = OP_SUM;
                state_next = ST_MOD_M;
            end
            ST_MOD_M: begin
                cmd.op     = OP_MOD;
                state_next = ST_REM_M;
            end
            ST_REM_M: begin
                cmd.op     = OP_REM;
                state_next = (sts.is_set && !sts.date_ok) ? ST_FAIL : ST_DIV_O;
            end
            ST_FAIL: begin
                cmd.op     = OP_FAIL;
                state_next = ST_DONE;
            end
            ST_DIV_O: begin
                cmd.op     = OP_DIV;
                cmd.sel    = SEL_OCT;
                state_next = ST_SUM_O;
            end
            ST_SUM_O: begin
                cmd.op     = OP_SUM;
                cmd.sel    = SEL_OCT;
                state_next = ST_MOD_O;
            end
            ST_MOD_O: begin
                cmd.op     = OP_MOD;
                cmd.sel    = SEL_OCT;
                state_next = ST_REM_O;
            end
            ST_REM_O: begin
                cmd.op     = OP_REM;
                cmd.sel    = SEL_OCT;
                state_next = ST_SWINIT;
            end
            ST_SWINIT: begin
                cmd.op     = OP_SWINIT;
                state_next = ST_SWEEP;
            end
            ST_SWEEP: begin
                if (sts.sweep_done) begin
                    state_next = ST_DAYS_M;
                end else begin
                    cmd.op = OP_SWEEP;
                end
            end
            ST_DAYS_M: begin
                cmd.op     = OP_DAYS;
                state_next = ST_MUL_M;
            end
            ST_MUL_M: begin
                cmd.op     = OP_MUL;
                state_next = ST_DAYS_O;
            end
            ST_DAYS_O: begin
                cmd.op     = OP_DAYS;
                cmd.sel    = SEL_OCT;
                state_next = ST_MUL_O;
            end
            ST_MUL_O: begin
                cmd.op     = OP_MUL;
                cmd.sel    = SEL_OCT;
                state_next = sts.is_set ? ST_DIV_D : ST_COMMIT;
            end
            ST_DIV_D: begin
                cmd.op     = OP_DIV;
                cmd.sel    = SEL_DATE;
                state_next = ST_SUM_D;
            end
            ST_SUM_D: begin
                cmd.op     = OP_SUM;
                cmd.sel    = SEL_DATE;
                state_next = ST_MOD_D;
            end
            ST_MOD_D: begin
                cmd.op     = OP_MOD;
                cmd.sel    = SEL_DATE;
                state_next = ST_REM_D;
            end
            ST_REM_D: begin
                cmd.op     = OP_REM;
                cmd.sel    = SEL_DATE;
                state_next = ST_DAYS_D;
            end
            ST_DAYS_D: begin
                cmd.op     = OP_DAYS;
                cmd.sel    = SEL_DATE;
                state_next = ST_MUL_D;
            end
            ST_MUL_D: begin
                cmd.op     = OP_MUL;
                cmd.sel    = SEL_DATE;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                cmd.op     = OP_COMMIT;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule
`default_nettype wire

[design/dct_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dct_checker
// Port-level checks of the calendar tick block, bound to the top level.
// ----------------------------------------------------------------------------
module dct_checker import dct_pkg::*; (
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire dct_req_t s_data,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire dct_res_t m_data
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("Result word present right after reset.");

    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Second word accepted while one is in work.");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Stalled result word changed.");

    a_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.now_second < 6'd60) && (m_data.now_minute < 6'd60)
                    && (m_data.weekday < 3'd7) && (m_data.now_month >= 4'd1)
                    && (m_data.now_month <= 4'd12))
        else $error("Result word holds an impossible time field.");

endmodule

bind dst_calendar_tick dct_checker u_dct_checker (.*);
`default_nettype wire

[bench/dst_calendar_tick_tb.sv]
// ----------------------------------------------------------------------------
// dst_calendar_tick_tb
// Self-checking bench for the calendar tick block. Directed set and tick words
// are followed by random traffic. A local calendar model predicts every result
// word, and the received words are compared against it field by field.
// ----------------------------------------------------------------------------
module dst_calendar_tick_tb;
    import dct_pkg::*;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SET  = 1'b1;
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_BAD   = 1'b1;
    localparam int   CYCLE_LIMIT = 2000000;
    localparam int   REQ_W = $bits(dct_req_t);

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    dct_req_t s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    dct_res_t m_data;

    dst_calendar_tick uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    logic [31:0] cal_utc, cal_sw_on, cal_sw_off;
    logic [11:0] cal_year;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day, cal_hour;
    logic [5:0]  cal_min, cal_sec;
    logic [2:0]  cal_wd;

    dct_res_t calendar_due[$];
    int errors = 0;
    int words_sent = 0;
    int words_checked = 0;
    int sets_sent = 0;
    int cycles = 0;
    int send_idle = 0;
    int recv_idle = 0;
    bit hold_recv = 1'b0;

    function automatic bit leap_year(input int unsigned y);
        if (y % 400 == 0) return 1'b1;
        if (y % 100 == 0) return 1'b0;
        return (y % 4) == 0;
    endfunction

    function automatic int unsigned month_len(input int unsigned m, input int unsigned y);
        int unsigned lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m < 1 || m > 12) return 0;
        if (m == 2 && leap_year(y)) return 29;
        return lens[m - 1];
    endfunction

    function automatic logic [31:0] secs_since_base(input int unsigned y, input int unsigned m,
            input int unsigned d, input int unsigned h, input int unsigned mi,
            input int unsigned s);
        logic [31:0] acc;
        acc = 0;
        for (int unsigned yy = BASE_YEAR; yy < y; yy++)
            acc += (leap_year(yy) ? 366 : 365) * 86400;
        for (int unsigned mm = 1; mm < m && mm <= 12; mm++)
            acc += 86400 * month_len(mm, y);
        acc += 32'((d - 1) * 86400 + h * 3600 + mi * 60 + s);
        return acc;
    endfunction

    function automatic logic [2:0] day_of_week(input int unsigned y, input int unsigned m,
            input int unsigned d);
        int unsigned cy, cm;
        cy = y;
        cm = m;
        if (m < 3) begin
            cm += 12;
            cy -= 1;
        end
        return 3'((d + 2 * cm + (6 * (cm + 1)) / 10 + cy + cy / 4 - cy / 100 + cy / 400 + 1) % 7);
    endfunction

    function automatic void find_dst_switches(input int unsigned y);
        cal_sw_on = secs_since_base(y, 3, 31, 1, 0, 0) - day_of_week(y, 3, 31) * 86400;
        cal_sw_off = secs_since_base(y, 10, 31, 1, 0, 0) - day_of_week(y, 10, 31) * 86400;
    endfunction

    function automatic void calendar_reset();
        cal_utc = 0;
        cal_year = 12'(BASE_YEAR);
        cal_month = 1;
        cal_day = 1;
        cal_hour = 0;
        cal_min = 0;
        cal_sec = 0;
        cal_wd = day_of_week(BASE_YEAR, 1, 1);
        cal_sw_on = 0;
        cal_sw_off = 0;
    endfunction

    function automatic void calendar_tick();
        cal_utc += 1;
        if (cal_utc == cal_sw_on) cal_hour += 1;
        if (cal_utc == cal_sw_off) cal_hour -= 1;
        if (cal_sec + 1 < 60) begin
            cal_sec += 1;
            return;
        end
        cal_sec = 0;
        if (cal_min + 1 < 60) begin
            cal_min += 1;
            return;
        end
        cal_min = 0;
        cal_hour += 1;
        if (cal_hour < 24) return;
        cal_hour = 0;
        cal_wd = (cal_wd >= 6) ? 3'd0 : cal_wd + 3'd1;
        if (int'(cal_day) + 1 <= month_len(cal_month, cal_year)) begin
            cal_day += 1;
            return;
        end
        cal_day = 1;
        if (cal_month + 1 <= 12) begin
            cal_month += 1;
            return;
        end
        cal_month = 1;
        cal_year += 1;
        find_dst_switches(cal_year);
    endfunction

    function automatic logic calendar_set(input dct_req_t r);
        logic [31:0] loc, utc;
        if (r.year < YEAR_MIN || r.year > YEAR_MAX) return ST_BAD;
        if (r.month < 1 || r.month > 12) return ST_BAD;
        if (r.hour > 23 || r.minute > 59 || r.second > 59) return ST_BAD;
        if (r.day < 1 || r.day > month_len(r.month, r.year)) return ST_BAD;
        find_dst_switches(r.year);
        loc = secs_since_base(r.year, r.month, r.day, r.hour, r.minute, r.second);
        utc = loc - 3600;
        if (utc > cal_sw_on && utc < cal_sw_off) utc = loc - 7200;
        cal_utc = utc;
        cal_year = r.year;
        cal_month = r.month;
        cal_day = r.day;
        cal_hour = r.hour;
        cal_min = r.minute;
        cal_sec = r.second;
        cal_wd = day_of_week(r.year, r.month, r.day);
        return ST_OK;
    endfunction

    function automatic dct_res_t calendar_step(input dct_req_t r);
        dct_res_t o;
        o.status = ST_OK;
        if (r.req_type == REQ_SET) o.status = calendar_set(r);
        else calendar_tick();
        o.now_year = cal_year;
        o.now_month = cal_month;
        o.now_day = cal_day;
        o.now_hour = cal_hour;
        o.now_minute = cal_min;
        o.now_second = cal_sec;
        o.weekday = cal_wd;
        o.summer_time = (cal_utc >= cal_sw_on) && (cal_utc < cal_sw_off);
        o.utc_seconds = cal_utc;
        return o;
    endfunction

    function automatic dct_req_t set_word(input int y, input int mo, input int d, input int h,
            input int mi, input int s);
        dct_req_t r;
        r.req_type = REQ_SET;
        r.year = 12'(y);
        r.month = 4'(mo);
        r.day = 5'(d);
        r.hour = 5'(h);
        r.minute = 6'(mi);
        r.second = 6'(s);
        return r;
    endfunction

    function automatic dct_req_t tick_word();
        dct_req_t r;
        r = REQ_W'({$urandom, $urandom});
        r.req_type = REQ_TICK;
        return r;
    endfunction

    task automatic send_word(input dct_req_t r);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= r;
        calendar_due.push_back(calendar_step(r));
        words_sent++;
        if (r.req_type == REQ_SET) sets_sent++;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Directed rows: a set word, how many ticks follow it, and, where obvious,
    // the status that the set must return.
    typedef struct {
        dct_req_t word;
        int       ticks;
        bit       has_status;
        logic     status;
    } dir_row_t;

    dir_row_t dir_rows[$];
    dct_res_t dir_fixed[$];
    bit       dir_check[$];

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !hold_recv && ($urandom_range(99) >= recv_idle);
        end
        if (aresetn && m_valid && m_ready) begin
            dct_res_t want;
            if (calendar_due.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                want = calendar_due.pop_front();
                if (dir_fixed.size() > 0) begin
                    if (dir_check.pop_front() && dir_fixed[0].status !== m_data.status) begin
                        $error("status (table) exp %0d got %0d", dir_fixed[0].status,
                            m_data.status);
                        errors++;
                    end
                    void'(dir_fixed.pop_front());
                end
                if (m_data.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, m_data.status); errors++;
                end
                if (m_data.now_year !== want.now_year) begin
                    $error("now_year exp %0d got %0d", want.now_year, m_data.now_year);
                    errors++;
                end
                if (m_data.now_month !== want.now_month) begin
                    $error("now_month exp %0d got %0d", want.now_month, m_data.now_month);
                    errors++;
                end
                if (m_data.now_day !== want.now_day) begin
                    $error("now_day exp %0d got %0d", want.now_day, m_data.now_day); errors++;
                end
                if (m_data.now_hour !== want.now_hour) begin
                    $error("now_hour exp %0d got %0d", want.now_hour, m_data.now_hour);
                    errors++;
                end
                if (m_data.now_minute !== want.now_minute) begin
                    $error("now_minute exp %0d got %0d", want.now_minute, m_data.now_minute);
                    errors++;
                end
                if (m_data.now_second !== want.now_second) begin
                    $error("now_second exp %0d got %0d", want.now_second, m_data.now_second);
                    errors++;
                end
                if (m_data.weekday !== want.weekday) begin
                    $error("weekday exp %0d got %0d", want.weekday, m_data.weekday); errors++;
                end
                if (m_data.summer_time !== want.summer_time) begin
                    $error("summer_time exp %0d got %0d", want.summer_time,
                        m_data.summer_time);
                    errors++;
                end
                if (m_data.utc_seconds !== want.utc_seconds) begin
                    $error("utc_seconds exp %0d got %0d", want.utc_seconds,
                        m_data.utc_seconds);
                    errors++;
                end
                words_checked++;
            end
        end
    end

    // Starts near a year end, a DST switch, or a random legal moment, or sends a random set word.
    task automatic random_set();
        int y, mo, d, h, mi, s, pick;
        dct_req_t w;
        pick = $urandom_range(9);
        y = $urandom_range(9) == 0 ? $urandom_range(BASE_YEAR + YEAR_SPAN, BASE_YEAR)
                                   : $urandom_range(BASE_YEAR + 30, BASE_YEAR);
        if (pick < 5) begin
            mo = $urandom_range(12, 1);
            d = $urandom_range(month_len(mo, y), 1);
            h = $urandom_range(23);
            mi = $urandom_range(59);
            s = $urandom_range(59);
            if (pick < 2) begin
                mi = 59;
                s = $urandom_range(59, 50);
                if (pick == 0) h = 23;
            end
        end else if (pick < 7) begin
            mo = 12; d = 31; h = 23; mi = 59; s = $urandom_range(59, 40);
        end else if (pick < 9) begin
            mo = pick == 7 ? 3 : 10;
            d = 31 - day_of_week(y, mo, 31);
            h = pick == 7 ? 1 : 2;
            mi = 59;
            s = $urandom_range(59, 45);
        end else begin
            w = tick_word();
            w.req_type = REQ_SET;
            send_word(w);
            return;
        end
        send_word(set_word(y, mo, d, h, mi, s));
    endtask

    initial begin
        int n;
        calendar_reset();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        dir_rows.push_back('{set_word(BASE_YEAR - 1, 6, 1, 0, 0, 0), 1, 1'b1, ST_BAD});
        dir_rows.push_back('{set_word(BASE_YEAR + YEAR_SPAN + 1, 6, 1, 0, 0, 0), 0, 1'b1,
            ST_BAD});
        dir_rows.push_back('{set_word(BASE_YEAR, 0, 1, 0, 0, 0), 0, 1'b1, ST_BAD});
        dir_rows.push_back('{set_word(BASE_YEAR, 13, 1, 0, 0, 0), 0, 1'b1, ST_BAD});
        dir_rows.push_back('{set_word(BASE_YEAR, 2, 0, 0, 0, 0), 0, 1'b1, ST_BAD});
        dir_rows.push_back('{set_word(BASE_YEAR + 1, 2, 29, 0, 0, 0), 0, 1'b1, ST_BAD});
        dir_rows.push_back('{set_word(BASE_YEAR, 4, 31, 0, 0, 0), 0, 1'b1, ST_BAD});
        dir_rows.push_back('{set_word(BASE_YEAR, 5, 5, 24, 0, 0), 0, 1'b1, ST_BAD});
        dir_rows.push_back('{set_word(BASE_YEAR, 5, 5, 0, 60, 0), 0, 1'b1, ST_BAD});
        dir_rows.push_back('{set_word(4095, 15, 31, 31, 63, 63), 0, 1'b1, ST_BAD});
        dir_rows.push_back('{set_word(BASE_YEAR, 1, 1, 0, 0, 0), 1, 1'b1, ST_OK});
        dir_rows.push_back('{set_word(BASE_YEAR, 2, 29, 23, 59, 59), 1, 1'b1, ST_OK});
        dir_rows.push_back('{set_word(BASE_YEAR, 3, 26, 1, 59, 58), 2, 1'b1, ST_OK});
        dir_rows.push_back('{set_word(BASE_YEAR, 10, 29, 2, 59, 58), 2, 1'b1, ST_OK});
        dir_rows.push_back('{set_word(BASE_YEAR + 99, 12, 31, 23, 59, 59), 2, 1'b1, ST_OK});
        dir_rows.push_back('{set_word(BASE_YEAR + YEAR_SPAN, 12, 31, 23, 59, 59), 1, 1'b1,
            ST_OK});
        dir_rows.push_back('{set_word(BASE_YEAR + 5, 7, 14, 12, 30, 0), 1, 1'b1, ST_OK});

        foreach (dir_rows[i]) begin
            dir_fixed.push_back('{status: dir_rows[i].status, default: '0});
            dir_check.push_back(dir_rows[i].has_status);
            send_word(dir_rows[i].word);
            for (int k = 0; k < dir_rows[i].ticks; k++) begin
                dir_fixed.push_back('0);
                dir_check.push_back(1'b0);
                send_word(tick_word());
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = phase == 0 ? 22 : (phase == 1 ? 65 : 0);
            recv_idle = phase == 0 ? 65 : (phase == 1 ? 22 : 0);
            n = 0;
            while (n < 260) begin
                random_set();
                n++;
                repeat ($urandom_range(25, 1)) begin
                    send_word(tick_word());
                    n++;
                end
                if (phase == 2 && n > 100 && n < 140) begin
                    hold_recv = 1'b1;
                    fork
                        begin
                            repeat (300) @(posedge aclk);
                            hold_recv = 1'b0;
                        end
                    join_none
                end
            end
        end
        s_valid <= 1'b0;

        while (calendar_due.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Checked %0d result words from %0d input words, %0d of them set words.",
            words_checked, words_sent, sets_sent);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

[dst_calendar_tick.f]
design/dct_pkg.sv
design/dct_datapath.sv
design/dct_ctrl.sv
design/dst_calendar_tick.sv
design/dct_checker.sv
bench/dst_calendar_tick_tb.sv
